[src/imad_pkg.sv]
// Package for the IMA ADPCM nibble decoder (4XM variant).
// Holds the queue entry and result types, the step table and the index adjust table.
// No dependencies; imported by every module of the decoder.
package imad_pkg;

   // Highest legal step table index.
   localparam logic [6:0] MAX_INDEX = 7'd88;

   // Predictor saturation bounds, 18-bit signed to match the widened sum.
   localparam logic signed [17:0] PRED_MIN = -18'sd32768;
   localparam logic signed [17:0] PRED_MAX = 18'sd32767;

   // One classified code byte waiting for the decoder.
   typedef struct packed {
      logic [7:0]         code_byte;
      logic               channel;
      logic               block_start;
      logic signed [15:0] start_predictor;
      logic [6:0]         start_index;
   } job_type;

   // One decoded sample on its way to the result channel.
   typedef struct packed {
      logic signed [15:0] sample;
      logic               sample_channel;
      logic               last;
   } rsp_type;

   // IMA step size for a step index; index 88 and above read 32767.
   function automatic logic [14:0] step_of(input logic [6:0] idx);
      logic [14:0] s;
      unique case (idx)
         7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
         7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
         7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
         7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
         7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
         7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
         7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
         7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
         7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
         7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
         7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
         7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
         7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
         7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
         7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
         7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
         7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
         7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
         7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
         7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
         7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
         7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
         7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
         7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
         7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
         7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
         7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
         7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
         7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
         7'd87: s = 15'd29794;
         default: s = 15'd32767;
      endcase
      return s;
   endfunction

   // Step index adjustment for a code; the sign bit does not matter.
   function automatic logic signed [7:0] index_adjust(input logic [3:0] code);
      logic signed [7:0] a;
      unique case (code[2:0])
         3'd4:    a = 8'sd2;
         3'd5:    a = 8'sd4;
         3'd6:    a = 8'sd6;
         3'd7:    a = 8'sd8;
         default: a = -8'sd1;
      endcase
      return a;
   endfunction

endpackage

[src/imad_front.sv]
// Front end of the IMA ADPCM decoder: accepts code bytes and classifies them.
// Resolves the channel and clamps the starting index; depends on imad_pkg.
module imad_front
   import imad_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_code_byte,
   input  logic               in_channel,
   input  logic               in_block_start,
   input  logic signed [15:0] in_start_predictor,
   input  logic [6:0]         in_start_index,
   output logic               push,
   output job_type            push_job,
   input  logic               queue_ready
);

   logic    front_valid_ff, front_valid_in;
   job_type front_job_ff;
   job_type front_job_in;

   // A channel beyond the configured count falls onto the last channel.
   always_comb begin
      front_job_in.code_byte       = in_code_byte;
      front_job_in.channel         = (int'(in_channel) >= CHANNELS) ? 1'(CHANNELS - 1)
                                                                    : in_channel;
      front_job_in.block_start     = in_block_start;
      front_job_in.start_predictor = in_start_predictor;
      front_job_in.start_index     = (in_start_index > MAX_INDEX) ? MAX_INDEX
                                                                 : in_start_index;
   end

   // The holding register frees up whenever its entry moves into the queue.
   assign push     = front_valid_ff && queue_ready;
   assign in_ready = !front_valid_ff || queue_ready;
   assign push_job = front_job_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (push) begin
         front_valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         front_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   // Payload holds unless a new byte is taken.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         front_job_ff <= front_job_in;
      end
   end

endmodule

[src/imad_queue.sv]
// Two-entry queue between the front end and the decoder of the IMA ADPCM block.
// Lets either side stall on its own; depends on imad_pkg for the entry type.
module imad_queue
   import imad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    push_ready,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[src/imad_back.sv]
// Decoder back end of the IMA ADPCM block: one nibble per cycle while the output register can take it.
// Holds the per-channel predictor and step index and the output register; uses imad_pkg.
module imad_back
   import imad_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    pop,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_rsp
);

   logic signed [15:0] pred_ff  [CHANNELS];
   logic [6:0]         index_ff [CHANNELS];
   logic               phase_ff, phase_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_rsp_ff;

   logic               out_free;
   logic               fire;
   logic               load_start;
   logic signed [15:0] cur_pred;
   logic [6:0]         cur_index;
   logic [3:0]         nibble;
   logic [14:0]        step;
   logic [18:0]        product;
   logic [14:0]        diff;
   logic signed [17:0] sum;
   logic signed [15:0] new_pred;
   logic signed [7:0]  index_sum;
   logic [6:0]         new_index;

   // A nibble is decoded when a byte waits and the output register can take it.
   assign out_free = !out_valid_ff || out_ready;
   assign fire     = job_valid && out_free;
   assign pop      = fire && phase_ff;

   // The block start values replace the stored state for the low nibble.
   assign load_start = job.block_start && !phase_ff;
   assign cur_pred   = load_start ? job.start_predictor : pred_ff[job.channel];
   assign cur_index  = load_start ? job.start_index : index_ff[job.channel];
   assign nibble     = phase_ff ? job.code_byte[7:4] : job.code_byte[3:0];

   // Difference ((2*m+1)*step)>>4, then the saturating predictor update.
   always_comb begin
      step    = step_of(cur_index);
      product = 19'({nibble[2:0], 1'b1}) * 19'(step);
      diff    = product[18:4];
      if (nibble[3]) begin
         sum = 18'(cur_pred) - $signed({3'b000, diff});
      end else begin
         sum = 18'(cur_pred) + $signed({3'b000, diff});
      end
      if (sum < PRED_MIN) begin
         new_pred = PRED_MIN[15:0];
      end else if (sum > PRED_MAX) begin
         new_pred = PRED_MAX[15:0];
      end else begin
         new_pred = sum[15:0];
      end
   end

   // Step index moves by the adjust table and stays within 0..88.
   always_comb begin
      index_sum = $signed({1'b0, cur_index}) + index_adjust(nibble);
      if (index_sum < 8'sd0) begin
         new_index = 7'd0;
      end else if (index_sum > $signed({1'b0, MAX_INDEX})) begin
         new_index = MAX_INDEX;
      end else begin
         new_index = index_sum[6:0];
      end
   end

   // Phase and output valid control.
   always_comb begin
      phase_in     = fire ? ~phase_ff : phase_ff;
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Per-channel decoder state; reset clears it to predictor 0, index 0.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            pred_ff[c]  <= '0;
            index_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (fire && (int'(job.channel) == c)) begin
               pred_ff[c]  <= new_pred;
               index_ff[c] <= new_index;
            end
         end
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_rsp_ff.sample         <= new_pred;
         out_rsp_ff.sample_channel <= job.channel;
         out_rsp_ff.last           <= phase_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

endmodule

[src/ima_adpcm_nibble_decoder.sv]
// IMA ADPCM decoder, 4XM variant: two 16-bit samples per code byte.
// Top level tying front end, queue and decoder together; uses imad_pkg.
//
// Usage:
//   The req_ stream carries one code byte per transfer with its channel and,
//   on the first byte of a block, the starting predictor and step index
//   (block start flag in req_tuser). The rsp_ stream returns two samples per
//   byte: the low-nibble sample first, then the high-nibble sample with
//   rsp_tlast set. rsp_tuser carries the sample's channel.
//   Each byte passes through the input register and the two-entry queue
//   to the decoder, which writes each sample into the output register.
//   The decoder runs one nibble per cycle, while the output register can
//   take a sample, through the step multiply and the channel's
//   predictor and index registers.
//   Reset clears both channels to predictor 0 and step index 0 and empties
//   all stages. When the receiver stalls, the output register holds its
//   sample, the two-entry queue and the input register fill, and then
//   req_tready drops until the decoder moves again.
module ima_adpcm_nibble_decoder
   import imad_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: code_byte[7:0], start_predictor[23:8], start_index[30:24], zero[31]
   input  logic [31:0] req_tdata,
   // req_tuser: channel[0], block_start[1]
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: sample[15:0]
   output logic [15:0] rsp_tdata,
   // rsp_tuser: sample_channel[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   logic    push;
   logic    push_ready;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;
   rsp_type out_rsp;

   imad_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_tvalid),
      .in_ready           (req_tready),
      .in_code_byte       (req_tdata[7:0]),
      .in_channel         (req_tuser[0]),
      .in_block_start     (req_tuser[1]),
      .in_start_predictor ($signed(req_tdata[23:8])),
      .in_start_index     (req_tdata[30:24]),
      .push               (push),
      .push_job           (push_job),
      .queue_ready        (push_ready)
   );

   imad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   imad_back #(
      .CHANNELS(CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (out_rsp)
   );

   assign rsp_tdata = out_rsp.sample;
   assign rsp_tuser = out_rsp.sample_channel;
   assign rsp_tlast = out_rsp.last;

endmodule

[src/imad_checker.sv]
// Port-level checks for the IMA ADPCM decoder top level.
// Bound to ima_adpcm_nibble_decoder; no package dependency.
module imad_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // A stalled sample stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The high-nibble sample of the same channel follows the low one at once.
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tlast && (rsp_tuser == $past(rsp_tuser)))
      else $error("high-nibble sample missing after low-nibble sample");

   // Reset empties the output register.
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Reset leaves the input side open.
   a_reset_in: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready right after reset");

endmodule

bind ima_adpcm_nibble_decoder imad_checker u_imad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
